>>> rtl/assert_macros.svh
// Assertion macros for the RTL of the cross-kernel sharpener.
// Needs nothing else; take it in by include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante held.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cks_pkg.sv
// Types, constants and channel arithmetic of the cross-kernel sharpener.
// Depends on nothing; the line store, top level, checker and testbench use it.
package cks_pkg;

  localparam int CFG_DW  = 12;
  localparam int COORD_W = 11;

  typedef logic [CFG_DW-1:0] cfg_data_t;
  typedef logic [1:0]        cfg_index_t;

  localparam cfg_index_t CFG_FRAME_WIDTH  = 2'd0;
  localparam cfg_index_t CFG_FRAME_HEIGHT = 2'd1;
  localparam cfg_index_t CFG_STRENGTH     = 2'd2;

  localparam cfg_data_t         RESET_WIDTH    = 12'd1280;
  localparam cfg_data_t         RESET_HEIGHT   = 12'd720;
  localparam logic signed [7:0] RESET_STRENGTH = 8'sd0;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // 100*c + s*d spans -32385 .. 57885
  typedef logic signed [16:0] mix_t;

  localparam int         PCT         = 100;
  localparam logic [7:0] CHAN_MAX    = 8'd255;
  localparam mix_t       SAT_SUM     = 17'sd25600;   // PCT * 256
  // floor(n / 100) == (n * 5243) >> 19 for 0 <= n < 43690
  localparam int         RECIP_100   = 5243;
  localparam int         RECIP_SHIFT = 19;

  // Blend center with the cross average: 100*c + s*(c - avg).
  function automatic mix_t sharpen_mix(input logic [7:0] c, input logic [7:0] l,
                                       input logic [7:0] r, input logic [7:0] t,
                                       input logic [7:0] b, input logic signed [7:0] s);
    logic [9:0]        sum;
    logic [7:0]        avg;
    logic signed [8:0] d;
    mix_t              prod;
    mix_t              base;
    sum  = 10'(l) + 10'(r) + 10'(t) + 10'(b);
    avg  = sum[9:2];
    d    = $signed({1'b0, c}) - $signed({1'b0, avg});
    prod = 17'(s) * 17'(d);
    base = $signed(17'(c) * 17'(PCT));
    return base + prod;
  endfunction

  // Floor-divide by 100 and clamp to 0..255.
  function automatic logic [7:0] sharpen_scale(input mix_t n);
    logic [27:0] q;
    q = (28'(n[14:0]) * 28'(RECIP_100)) >> RECIP_SHIFT;
    if (n[16]) begin
      return '0;
    end else if (n >= SAT_SUM) begin
      return CHAN_MAX;
    end
    return q[7:0];
  endfunction

endpackage

>>> rtl/cks_if.sv
// Valid/ready channel interfaces for incoming pixels and result pixels.
// Stand-alone; the top level of the sharpener uses both.
interface cks_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source(output valid, output red_in, output green_in, output blue_in,
                 input ready);
  modport sink(input valid, input red_in, input green_in, input blue_in,
               output ready);
endinterface

interface cks_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [10:0] column;
  logic [10:0] row;
  logic        last_of_run;
  logic        frame_done;

  modport source(output valid, output red_out, output green_out, output blue_out,
                 output column, output row, output last_of_run, output frame_done,
                 input ready);
  modport sink(input valid, input red_out, input green_out, input blue_out,
               input column, input row, input last_of_run, input frame_done,
               output ready);
endinterface

>>> rtl/cks_line_store.sv
// One row of pixels: written at one column, read at that column and the next.
// Depends on cks_pkg for the pixel type.
module cks_line_store #(
  parameter int DEPTH = 2048,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic            wr_en,
  input  logic [AW-1:0]   addr,
  input  cks_pkg::pixel_t wr_data,
  output cks_pkg::pixel_t data_here,
  output cks_pkg::pixel_t data_next
);
  import cks_pkg::*;

  pixel_t        mem [DEPTH];
  logic [AW-1:0] addr_next;

  // wraps at the end of the store; that read is never used
  assign addr_next = AW'(addr + 1'b1);

  // read-before-write: a read of the written column returns the old pixel
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_here <= mem[addr];
      data_next <= mem[addr_next];
    end
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

endmodule

>>> rtl/cross_kernel_sharpen.sv
// Cross-kernel sharpener: takes RGB pixels in raster order and returns each
// pixel sharpened against the floored average of its left, right, upper and
// lower neighbours by strength/100, clamped to 0..255; frame-border pixels
// pass through unchanged. Results carry their column and row; all but the
// last row's pass-through results trail by one row. Each last-row pixel below
// row 0 returns two results (the pixel above, then itself), so there the
// output port limits the pace; other rows run at one pixel per clock while
// results are taken. Each result passes the line-store read at accept, blend
// multiply, then divide-by-100 and clamp, each ending in a register; a full
// output stalls them. The user must see that width, height and strength are
// written through the cfg port while the block is idle, unenforced by the block.
// Depends on cks_pkg, cks_if, cks_line_store and assert_macros.svh.
`include "assert_macros.svh"

module cross_kernel_sharpen #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                clk,
  input  logic                rst,
  cks_pixel_if.sink           pixels,
  cks_result_if.source        results,
  input  logic                cfg_write,
  input  cks_pkg::cfg_index_t cfg_index,
  input  cks_pkg::cfg_data_t  cfg_data
);
  import cks_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  typedef struct packed {
    pixel_t             pix;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               last;
    logic               done;
  } result_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_data_t         frame_width;
  cfg_data_t         frame_height;
  logic signed [7:0] strength;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
      strength     <= RESET_STRENGTH;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        CFG_STRENGTH:     strength     <= $signed(cfg_data[7:0]);
        default: ;
      endcase
    end
  end

  // Effective frame size: zero acts as one, anything beyond the stores saturates.
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [XW-1:0] w_last;
  logic [YW-1:0] h_last;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if (frame_width > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = HW'(1);
    end else if (frame_height > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height);
    end
    w_last = XW'(w_eff - 1'b1);
    h_last = YW'(h_eff - 1'b1);
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow: each stage advances when the stage after it has room.
  // ---------------------------------------------------------------------------
  logic       s1_valid;
  logic       s2_valid;
  logic [1:0] slot_valid;     // [0]: pixel above, [1]: last-row pass-through
  logic       s3_free;
  logic       s2_free;
  logic       s1_free;
  logic       s2_adv;
  logic       s1_adv;
  logic       accept;
  logic       out_take;

  assign out_take = results.valid && results.ready;
  // the result slots take a new pair only once both drain this cycle
  assign s3_free  = (slot_valid == 2'b00) ||
                    (results.ready && (slot_valid != 2'b11));
  assign s2_adv   = s2_valid && s3_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_adv   = s1_valid && s2_free;
  assign s1_free  = !s1_valid || s2_free;
  assign pixels.ready = s1_free;
  assign accept   = pixels.valid && s1_free;

  // ---------------------------------------------------------------------------
  // Raster position and line-store roles
  // ---------------------------------------------------------------------------
  logic [XW-1:0] column_count;
  logic [YW-1:0] row_count;
  logic          store_select;  // 0: store A holds the row above the current one
  logic          row_end;
  logic          last_row;
  logic          interior;
  logic          has_above;
  pixel_t        pix_cur;

  assign pix_cur   = {pixels.red_in, pixels.green_in, pixels.blue_in};
  assign row_end   = column_count >= w_last;
  assign last_row  = row_count >= h_last;
  assign has_above = row_count != '0;
  // the pixel one row up is interior when it is off every frame edge
  assign interior  = (column_count != '0) && !row_end &&
                     (row_count > YW'(1)) && (row_count <= h_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      store_select <= 1'b0;
    end else if (accept) begin
      if (row_end) begin
        column_count <= '0;
        store_select <= !store_select;
        row_count    <= last_row ? '0 : YW'(row_count + 1'b1);
      end else begin
        column_count <= XW'(column_count + 1'b1);
      end
    end
  end

  // Both stores read the current column and the next; the older one takes the
  // incoming pixel and so becomes the row above once this row ends.
  pixel_t a_here;
  pixel_t a_next;
  pixel_t b_here;
  pixel_t b_next;

  cks_line_store #(.DEPTH(MAX_WIDTH)) u_store_a (
    .clk       (clk),
    .rd_en     (accept),
    .wr_en     (accept && store_select),
    .addr      (column_count),
    .wr_data   (pix_cur),
    .data_here (a_here),
    .data_next (a_next)
  );

  cks_line_store #(.DEPTH(MAX_WIDTH)) u_store_b (
    .clk       (clk),
    .rd_en     (accept),
    .wr_en     (accept && !store_select),
    .addr      (column_count),
    .wr_data   (pix_cur),
    .data_here (b_here),
    .data_next (b_next)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: neighbours are in hand; blend each channel.
  // ---------------------------------------------------------------------------
  pixel_t        s1_cur;
  logic [XW-1:0] s1_x;
  logic [YW-1:0] s1_y;
  logic          s1_sel;
  logic          s1_interior;
  logic          s1_has_above;
  logic          s1_last_row;
  logic          s1_row_end;
  pixel_t        left_above_pixel;
  pixel_t        center_px;
  pixel_t        right_px;
  pixel_t        top_px;
  mix_t          s1_mix_red;
  mix_t          s1_mix_green;
  mix_t          s1_mix_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur       <= pix_cur;
      s1_x         <= column_count;
      s1_y         <= row_count;
      s1_sel       <= store_select;
      s1_interior  <= interior;
      s1_has_above <= has_above;
      s1_last_row  <= last_row;
      s1_row_end   <= row_end;
    end
  end

  assign center_px = s1_sel ? b_here : a_here;
  assign right_px  = s1_sel ? b_next : a_next;
  assign top_px    = s1_sel ? a_here : b_here;

  // Hold the previous item's center: it is the left neighbour of this one.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_above_pixel <= '0;
    end else if (s1_adv) begin
      left_above_pixel <= center_px;
    end
  end

  // the incoming pixel is the lower neighbour
  assign s1_mix_red   = sharpen_mix(center_px.red, left_above_pixel.red, right_px.red,
                                    top_px.red, s1_cur.red, strength);
  assign s1_mix_green = sharpen_mix(center_px.green, left_above_pixel.green,
                                    right_px.green, top_px.green, s1_cur.green,
                                    strength);
  assign s1_mix_blue  = sharpen_mix(center_px.blue, left_above_pixel.blue,
                                    right_px.blue, top_px.blue, s1_cur.blue, strength);

  // ---------------------------------------------------------------------------
  // Stage 2: divide by 100, clamp, and build the result pair.
  // ---------------------------------------------------------------------------
  mix_t          s2_mix_red;
  mix_t          s2_mix_green;
  mix_t          s2_mix_blue;
  pixel_t        s2_center;
  pixel_t        s2_cur;
  logic [XW-1:0] s2_x;
  logic [YW-1:0] s2_y;
  logic [YW-1:0] s2_y_above;
  logic          s2_interior;
  logic          s2_has_above;
  logic          s2_last_row;
  logic          s2_row_end;
  pixel_t        sharp_px;
  pixel_t        res_above;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_mix_red   <= s1_mix_red;
      s2_mix_green <= s1_mix_green;
      s2_mix_blue  <= s1_mix_blue;
      s2_center    <= center_px;
      s2_cur       <= s1_cur;
      s2_x         <= s1_x;
      s2_y         <= s1_y;
      s2_interior  <= s1_interior;
      s2_has_above <= s1_has_above;
      s2_last_row  <= s1_last_row;
      s2_row_end   <= s1_row_end;
    end
  end

  assign sharp_px.red   = sharpen_scale(s2_mix_red);
  assign sharp_px.green = sharpen_scale(s2_mix_green);
  assign sharp_px.blue  = sharpen_scale(s2_mix_blue);
  assign res_above      = s2_interior ? sharp_px : s2_center;
  assign s2_y_above     = YW'(s2_y - 1'b1);

  // ---------------------------------------------------------------------------
  // Stage 3: two result slots; the pixel above leaves before the pass-through.
  // ---------------------------------------------------------------------------
  result_t    slot_a;
  result_t    slot_b;
  result_t    head;
  logic [1:0] slot_valid_next;

  // drop the slot that leaves; a new pair replaces whatever remains
  always_comb begin
    slot_valid_next = slot_valid;
    if (out_take) begin
      if (slot_valid[0]) begin
        slot_valid_next[0] = 1'b0;
      end else begin
        slot_valid_next[1] = 1'b0;
      end
    end
    if (s2_adv) begin
      slot_valid_next = {s2_last_row, s2_has_above};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 2'b00;
    end else begin
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      slot_a.pix    <= res_above;
      slot_a.column <= COORD_W'(s2_x);
      slot_a.row    <= COORD_W'(s2_y_above);
      slot_a.last   <= !s2_last_row;
      slot_a.done   <= 1'b0;
      slot_b.pix    <= s2_cur;
      slot_b.column <= COORD_W'(s2_x);
      slot_b.row    <= COORD_W'(s2_y);
      slot_b.last   <= 1'b1;
      slot_b.done   <= s2_row_end;
    end
  end

  assign head                = slot_valid[0] ? slot_a : slot_b;
  assign results.valid       = |slot_valid;
  assign results.red_out     = head.pix.red;
  assign results.green_out   = head.pix.green;
  assign results.blue_out    = head.pix.blue;
  assign results.column      = head.column;
  assign results.row         = head.row;
  assign results.last_of_run = head.last;
  assign results.frame_done  = head.done;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_IMPLIES(a_done_is_last, clk, rst, results.valid && results.frame_done,
    results.last_of_run, "frame_done on a result that is not last of its run")
  `ASSERT_IMPLIES(a_pair_first_not_last, clk, rst, slot_valid == 2'b11,
    !slot_a.last, "first of a result pair marked last_of_run")
  `ASSERT_NEXT(a_accept_fills_s1, clk, rst, accept, s1_valid,
    "accepted pixel did not reach stage 1")
  `ASSERT_NEXT(a_swap_at_row_end, clk, rst, accept && row_end,
    store_select != $past(store_select), "line stores did not swap at row end")

endmodule

>>> tb/sv/cks_checker.sv
`timescale 1ns / 100ps
// Result checker of the cross-kernel sharpener: watches the pixel, result and cfg ports,
// predicts every result item from its own copy of the line stores, compares field by field.
// Depends on cks_pkg and on the cks_pixel_if and cks_result_if interfaces.
module cks_checker
  import cks_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic       clk,
  input  logic       rst,
  cks_pixel_if       pixels,
  cks_result_if      results,
  input  logic       cfg_write,
  input  cfg_index_t cfg_index,
  input  cfg_data_t  cfg_data,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    pixel_t               px;
    logic [COORD_W-1:0]   column;
    logic [COORD_W-1:0]   row;
    logic                 last_of_run;
    logic                 frame_done;
  } sharpened_t;

  sharpened_t        sharpened_q[$];
  pixel_t            row_store [0:1][0:MAX_WIDTH-1];
  pixel_t            left_above;
  int unsigned       col_count;
  int unsigned       row_count;
  bit                store_sel;
  cfg_data_t         width_reg;
  cfg_data_t         height_reg;
  logic signed [7:0] strength_reg;
  int                errors;

  function automatic int unsigned bounded(input cfg_data_t v, input int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // floor((100*c + s*(c - avg)) / 100), clamped to one channel
  function automatic logic [7:0] sharpen_channel(input logic [7:0] c, input logic [7:0] l,
                                                 input logic [7:0] r, input logic [7:0] t,
                                                 input logic [7:0] b,
                                                 input logic signed [7:0] s);
    int avg;
    int num;
    int quo;
    avg = (int'(l) + int'(r) + int'(t) + int'(b)) / 4;
    num = PCT * int'(c) + int'(s) * (int'(c) - avg);
    quo = num / PCT;
    if (num < 0 && num % PCT != 0) quo = quo - 1;
    if (quo < 0) quo = 0;
    if (quo > int'(CHAN_MAX)) quo = int'(CHAN_MAX);
    return 8'(quo);
  endfunction

  // Take one pixel item: queue the results it causes and advance the raster position.
  task automatic advance_frame(input pixel_t cur);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    pixel_t      center;
    pixel_t      right;
    pixel_t      top;
    pixel_t      res;
    bit          last_row;
    bit          row_end;
    w        = bounded(width_reg, MAX_WIDTH);
    h        = bounded(height_reg, MAX_HEIGHT);
    x        = col_count;
    y        = row_count;
    last_row = (y >= h - 1);
    row_end  = (x >= w - 1);
    center   = row_store[store_sel][x];
    right    = (x + 1 < MAX_WIDTH) ? row_store[store_sel][x + 1] : '0;
    top      = row_store[!store_sel][x];
    if (y >= 1) begin
      res = center;
      if (x >= 1 && x + 2 <= w && y >= 2 && y + 1 <= h) begin
        res.red   = sharpen_channel(center.red, left_above.red, right.red, top.red,
                                    cur.red, strength_reg);
        res.green = sharpen_channel(center.green, left_above.green, right.green, top.green,
                                    cur.green, strength_reg);
        res.blue  = sharpen_channel(center.blue, left_above.blue, right.blue, top.blue,
                                    cur.blue, strength_reg);
      end
      sharpened_q.push_back('{px: res, column: COORD_W'(x), row: COORD_W'(y - 1),
                              last_of_run: !last_row, frame_done: 1'b0});
    end
    if (last_row) begin
      sharpened_q.push_back('{px: cur, column: COORD_W'(x), row: COORD_W'(y),
                              last_of_run: 1'b1, frame_done: row_end});
    end
    row_store[!store_sel][x] = cur;
    left_above = center;
    if (row_end) begin
      col_count = 0;
      store_sel = !store_sel;
      row_count = last_row ? 0 : y + 1;
    end else begin
      col_count = x + 1;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    sharpened_t want;
    if (rst) begin
      sharpened_q.delete();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_store[0][i] = '0;
        row_store[1][i] = '0;
      end
      left_above   = '0;
      col_count    = 0;
      row_count    = 0;
      store_sel    = 1'b0;
      width_reg    = RESET_WIDTH;
      height_reg   = RESET_HEIGHT;
      strength_reg = RESET_STRENGTH;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  width_reg = cfg_data;
          CFG_FRAME_HEIGHT: height_reg = cfg_data;
          CFG_STRENGTH:     strength_reg = cfg_data[7:0];
          default: ;
        endcase
      end
      if (pixels.valid && pixels.ready) begin
        advance_frame('{red: pixels.red_in, green: pixels.green_in, blue: pixels.blue_in});
      end
      if (results.valid && results.ready) begin
        if (sharpened_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, actual column %0d row %0d",
                   $time, results.column, results.row);
        end else begin
          want = sharpened_q.pop_front();
          check_field("red", want.px.red, results.red_out);
          check_field("green", want.px.green, results.green_out);
          check_field("blue", want.px.blue, results.blue_out);
          check_field("column", want.column, results.column);
          check_field("row", want.row, results.row);
          check_field("last_of_run", want.last_of_run, results.last_of_run);
          check_field("frame_done", want.frame_done, results.frame_done);
        end
      end
    end
    mismatches  <= errors;
    outstanding <= sharpened_q.size();
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the cross-kernel sharpener testbench: clock, reset, pixel stimulus, result stalls,
// cfg writes and the verdict. Depends on cks_pkg, the interfaces, the block and cks_checker.
module testbench;
  import cks_pkg::*;

  localparam int MAX_WIDTH      = 2048;
  localparam int MAX_HEIGHT     = 2048;
  // Settling wait after the last result is back; leave generous slack.
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 20;
  // Longest quiet stretch of a correct run is the longest random stall plus a cfg pause.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1700;
  // Index that names no register; the block must ignore writes to it.
  localparam cfg_index_t CFG_UNUSED = 2'd3;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;
  int         mismatches;
  int         outstanding;
  int         stall_cycles;
  int         random_sent;
  bit         calm;          // when set, neither side idles

  cks_pixel_if  pix();
  cks_result_if res();

  cross_kernel_sharpen #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .pixels   (pix),
    .results  (res),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  cks_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) sharpen_check (
    .clk        (clk),
    .rst        (rst),
    .pixels     (pix),
    .results    (res),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_length();
    int pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Lean toward 0 and 255 so that both clamps get hit often.
  function automatic logic [7:0] random_channel();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return 8'h00;
    if (pick < 4) return CHAN_MAX;
    return 8'($urandom);
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.red   = random_channel();
    p.green = random_channel();
    p.blue  = random_channel();
    return p;
  endfunction

  function automatic int random_strength();
    case ($urandom_range(0, 7))
      0: return -128;
      1: return 127;
      2: return -100;
      3: return 100;
      default: return $signed(8'($urandom));
    endcase
  endfunction

  // Offer one item, with an optional gap first; return at the edge that accepts it.
  task automatic push_pixel(input pixel_t p);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid    <= 1'b1;
    pix.red_in   <= p.red;
    pix.green_in <= p.green;
    pix.blue_in  <= p.blue;
    do @(posedge clk); while (pix.ready !== 1'b1);
  endtask

  task automatic send_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      push_pixel(random_pixel());
    end
  endtask

  // Checkerboard 4x3 frame: the interior pixels see red and green neighbours at the
  // opposite full-scale level, which drives both clamps with either sign of strength.
  task automatic send_checkerboard();
    logic [7:0] stripes [4];
    pixel_t     p;
    bit         odd;
    stripes = '{8'h00, 8'hFF, 8'hAA, 8'h55};
    for (int i = 0; i < 12; i++) begin
      odd     = ((i % 4) + (i / 4)) % 2;
      p.red   = odd ? CHAN_MAX : 8'h00;
      p.green = odd ? 8'h00 : CHAN_MAX;
      p.blue  = stripes[i % 4] ^ (odd ? 8'hFF : 8'h00);
      push_pixel(p);
    end
  endtask

  // Drop valid and hold until every expected result is back and the pipeline is empty.
  task automatic wait_idle();
    pix.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Caller lowers cfg_write after its last write.
  task automatic write_reg(input cfg_index_t index, input cfg_data_t data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h, input int s);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, cfg_data_t'(w));
    write_reg(CFG_FRAME_HEIGHT, cfg_data_t'(h));
    // junk in the unused upper data bits must not reach the strength register
    write_reg(CFG_STRENGTH, {4'($urandom), 8'(s)});
    cfg_write <= 1'b0;
  endtask

  // Result side: alternate ready bursts and stalls of random length.
  initial begin
    int hold;
    bit level;
    res.ready = 1'b0;
    hold      = 0;
    level     = 1'b0;
    forever begin
      @(posedge clk);
      while (hold == 0) begin
        level = !level;
        if (level) hold = $urandom_range(1, 24);
        else hold = idle_length();
      end
      res.ready <= level;
      hold--;
    end
  end

  // Watchdog: end the run when neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned w;
    int unsigned h;
    int          frames;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = CFG_FRAME_WIDTH;
    cfg_data     = '0;
    pix.valid    = 1'b0;
    pix.red_in   = '0;
    pix.green_in = '0;
    pix.blue_in  = '0;
    calm         = 1'b0;
    random_sent  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: full-scale checkerboards at both strength extremes.
    set_frame(4, 3, 127);
    send_checkerboard();
    set_frame(4, 3, -128);
    send_checkerboard();
    // Zero width and height act as a one-pixel frame.
    set_frame(0, 0, 0);
    send_pixels(1);

    // A frame of one row only passes its pixels through.
    set_frame(3, 1, random_strength());
    send_pixels(3);

    // Shrink the width mid-frame: column 4 is past the new last column, so the
    // next item ends row 2 and the last row holds three pixels.
    set_frame(6, 4, 100);
    send_pixels(16);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 12'd3);
    cfg_write <= 1'b0;
    send_pixels(4);

    // Shrink the height mid-frame: row 3 becomes the last row at once.
    set_frame(4, 6, -100);
    send_pixels(12);
    wait_idle();
    write_reg(CFG_FRAME_HEIGHT, 12'd2);
    write_reg(CFG_UNUSED, cfg_data_t'($urandom));
    cfg_write <= 1'b0;
    send_pixels(4);

    // Random: whole frames under random settings, mostly small frames.
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: w = $urandom_range(1, 8);
        14, 15, 16, 17, 18: w = $urandom_range(9, 40);
        default: w = $urandom_range(41, 300);
      endcase
      if (w > 40) h = $urandom_range(1, 3);
      else if ($urandom_range(0, 4) == 0) h = $urandom_range(7, 16);
      else h = $urandom_range(1, 6);
      frames = (w > 40) ? 1 : $urandom_range(1, 3);
      calm = ($urandom_range(0, 5) == 0);
      set_frame(w, h, random_strength());
      send_pixels(frames * w * h);
      random_sent += frames * w * h;
    end

    calm = 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/cks_pkg.sv
rtl/cks_if.sv
rtl/cks_line_store.sv
rtl/cross_kernel_sharpen.sv
tb/sv/cks_checker.sv
tb/sv/testbench.sv
